### rtl/pva_pkg.sv
// Shared constants, codes and handshake structs for the voice allocator.
package pva_pkg;

    localparam int VOICES = 8;
    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int AGE_W  = 32;
    localparam int LIM_W  = 5;
    localparam logic [LIM_W-1:0] VOICES_LIM = LIM_W'(VOICES);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FIND    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STEAL_NONE = 2'd0,
        STEAL_OLD  = 2'd1,
        STEAL_LOW  = 2'd2,
        STEAL_HIGH = 2'd3
    } t_steal;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic search;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_search;
        logic last;
    } t_sts;

endpackage

### rtl/pva_ctrl.sv
// Sequencer for the voice allocator: load, table scan, victim search, commit.
module pva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pva_pkg::t_sts i_sts,
    output pva_pkg::t_cmd o_cmd
);
    import pva_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SRCH   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = i_sts.need_search ? S_SRCH : S_COMMIT;
            end
            S_SRCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !busy)
        else $error("commit not followed by idle");

    a_search_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.search && i_sts.last) |=> o_cmd.commit)
        else $error("search end did not lead to commit");

endmodule

### rtl/pva_dp.sv
// Voice table datapath: slot storage, match scan, victim search and commit.
module pva_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pva_pkg::t_cmd i_cmd,
    output pva_pkg::t_sts o_sts,
    input  logic [1:0]    i_op,
    input  logic [3:0]    i_channel,
    input  logic [6:0]    i_note,
    input  logic [6:0]    i_velocity,
    input  logic [15:0]   i_voice_mask,
    input  logic [4:0]    i_poly_limit,
    input  logic [1:0]    i_steal_mode,
    input  logic [3:0]    i_target_slot,
    output logic          o_strobe,
    output logic [3:0]    o_slot,
    output logic          o_valid_res,
    output logic          o_gated,
    output logic [3:0]    o_slot_channel,
    output logic [6:0]    o_slot_note,
    output logic [6:0]    o_slot_velocity
);
    import pva_pkg::*;

    // slot table
    logic [VOICES-1:0] r_gated;
    logic [3:0]        r_chan [VOICES];
    logic [6:0]        r_note [VOICES];
    logic [6:0]        r_vel  [VOICES];
    logic [AGE_W-1:0]  r_age  [VOICES];
    logic [AGE_W-1:0]  r_serial;

    // latched beat
    t_op               r_op;
    logic [3:0]        r_ch;
    logic [6:0]        r_nt;
    logic [6:0]        r_vin;
    logic [VOICES-1:0] r_mask;
    logic [LIM_W-1:0]  r_limit;
    t_steal            r_mode;
    logic [3:0]        r_tgt;

    // scan results
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic              r_free_ok;
    logic [SLOT_W-1:0] r_free_idx;
    logic [VOICES-1:0] r_cand;
    logic              r_at_limit;

    // search state
    logic [CNT_W-1:0]  r_idx;
    logic              r_pick_ok;
    logic [SLOT_W-1:0] r_pick;
    logic [AGE_W-1:0]  r_best;

    logic              r_strobe;

    // scan logic
    logic [VOICES-1:0] match, own, free;
    logic [LIM_W-1:0]  held, eff_limit;
    logic [SLOT_W-1:0] hit_idx, free_idx;

    always_comb begin
        held     = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < VOICES; i++) begin
            match[i] = r_gated[i] && (r_chan[i] == r_ch) && (r_note[i] == r_nt);
            own[i]   = r_gated[i] && (r_chan[i] == r_ch);
            free[i]  = r_mask[i] && !r_gated[i];
            held     = held + LIM_W'(own[i]);
        end
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (match[i]) hit_idx = SLOT_W'(i);
            if (free[i])  free_idx = SLOT_W'(i);
        end
        eff_limit = (r_limit == '0) ? LIM_W'(1) : r_limit;
    end

    // single read port: search index while searching, else the target slot
    logic [SLOT_W-1:0] rd_idx;
    logic              rd_gated;
    logic [3:0]        rd_chan;
    logic [6:0]        rd_note, rd_vel;
    logic [AGE_W-1:0]  rd_age, key;

    always_comb begin
        rd_idx   = i_cmd.search ? r_idx[SLOT_W-1:0] : r_tgt[SLOT_W-1:0];
        rd_gated = r_gated[rd_idx];
        rd_chan  = r_chan[rd_idx];
        rd_note  = r_note[rd_idx];
        rd_vel   = r_vel[rd_idx];
        rd_age   = r_age[rd_idx];
        case (r_mode)
            STEAL_LOW:  key = {{(AGE_W-7){1'b0}}, rd_note};
            STEAL_HIGH: key = {{(AGE_W-7){1'b0}}, ~rd_note};  // lower key = higher note
            default:    key = rd_age;
        endcase
    end

    logic cand_here;
    assign cand_here = r_cand[rd_idx] && rd_gated;

    // commit decision
    logic              tgt_in;
    logic              res_ok, retrig, new_alloc;
    logic [SLOT_W-1:0] res_slot;

    always_comb begin
        tgt_in    = ({1'b0, r_tgt} < VOICES_LIM);
        res_ok    = 1'b0;
        retrig    = 1'b0;
        new_alloc = 1'b0;
        res_slot  = '0;
        case (r_op)
            OP_ALLOC: begin
                if (r_hit) begin
                    res_ok   = 1'b1;
                    retrig   = 1'b1;
                    res_slot = r_hit_idx;
                end else if (r_mask != '0) begin
                    if (r_at_limit || !r_free_ok) begin
                        res_ok   = r_pick_ok && (r_mode != STEAL_NONE);
                        res_slot = r_pick;
                    end else begin
                        res_ok   = 1'b1;
                        res_slot = r_free_idx;
                    end
                    new_alloc = res_ok;
                end
            end
            OP_FIND: begin
                res_ok   = r_hit;
                res_slot = r_hit_idx;
            end
            default: begin
                res_ok = tgt_in;
            end
        endcase
    end

    logic [AGE_W-1:0] serial_inc;
    assign serial_inc = r_serial + AGE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gated   <= '0;
            r_serial  <= '0;
            r_strobe  <= 1'b0;
            r_pick_ok <= 1'b0;
            r_idx     <= '0;
            for (int i = 0; i < VOICES; i++) begin
                r_chan[i] <= '0;
                r_note[i] <= '0;
                r_vel[i]  <= '0;
                r_age[i]  <= '0;
            end
        end else begin
            r_strobe <= i_cmd.commit;
            if (i_cmd.load) begin
                r_op    <= t_op'(i_op);
                r_ch    <= i_channel;
                r_nt    <= i_note;
                r_vin   <= i_velocity;
                r_mask  <= i_voice_mask[VOICES-1:0];
                r_limit <= i_poly_limit;
                r_mode  <= t_steal'(i_steal_mode);
                r_tgt   <= i_target_slot;
            end
            if (i_cmd.scan) begin
                r_hit      <= |match;
                r_hit_idx  <= hit_idx;
                r_free_ok  <= |free;
                r_free_idx <= free_idx;
                r_at_limit <= (held >= eff_limit);
                r_cand     <= (held >= eff_limit) ? own : r_mask;
                r_idx      <= '0;
                r_pick_ok  <= 1'b0;
            end
            if (i_cmd.search) begin
                r_idx <= r_idx + CNT_W'(1);
                // strict compare keeps the lowest slot on ties
                if (cand_here && (!r_pick_ok || key < r_best)) begin
                    r_pick_ok <= 1'b1;
                    r_pick    <= rd_idx;
                    r_best    <= key;
                end
            end
            if (i_cmd.commit) begin
                o_valid_res <= res_ok;
                if (r_op == OP_ALLOC || r_op == OP_FIND) begin
                    o_slot <= res_ok ? 4'(res_slot) : 4'd0;
                end else begin
                    o_slot <= r_tgt;
                end
                if (r_op == OP_READ && tgt_in) begin
                    o_gated         <= rd_gated;
                    o_slot_channel  <= rd_chan;
                    o_slot_note     <= rd_note;
                    o_slot_velocity <= rd_vel;
                end else begin
                    o_gated         <= 1'b0;
                    o_slot_channel  <= '0;
                    o_slot_note     <= '0;
                    o_slot_velocity <= '0;
                end
                if (retrig || new_alloc) begin
                    r_serial        <= serial_inc;
                    r_age[res_slot] <= serial_inc;
                    r_vel[res_slot] <= r_vin;
                end
                if (new_alloc) begin
                    r_gated[res_slot] <= 1'b1;
                    r_chan[res_slot]  <= r_ch;
                    r_note[res_slot]  <= r_nt;
                end
                if (r_op == OP_RELEASE && tgt_in) begin
                    r_gated[r_tgt[SLOT_W-1:0]] <= 1'b0;
                    r_chan[r_tgt[SLOT_W-1:0]]  <= '0;
                    r_note[r_tgt[SLOT_W-1:0]]  <= '0;
                end
            end
        end
    end

    assign o_strobe          = r_strobe;
    assign o_sts.need_search = (r_op == OP_ALLOC);
    assign o_sts.last        = (r_idx == CNT_W'(VOICES - 1));

    a_pick_is_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pick_ok |-> r_cand[r_pick])
        else $error("victim outside candidate set");

    a_serial_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.commit) |-> $stable(r_serial))
        else $error("age counter moved outside commit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !o_valid_res && !o_gated) |-> (o_slot_note == '0))
        else $error("read fields set on a miss");

endmodule

### rtl/poly_voice_allocator_unit.sv
// Top level of the polyphonic voice allocator with voice stealing.
// Usage: drive the operation fields and pulse start while busy is low; the
// beat is taken at that edge and busy stays high until the result is out.
// Operations: note-on allocate (retrigger, polyphony-limit steal, first
// free slot in the mask, or steal within the mask), find, release, read.
// Result: one beat per command, shown for exactly one cycle with o_strobe.
// Sequence after the accepting edge: table scan, then (allocate only) the
// victim search, one slot per cycle through the single read port, then
// commit, which registers the result shown with o_strobe.
// A new command may be accepted in the strobe cycle.
// Reset (synchronous, active low) frees every slot, zeroes all stored
// fields and the age counter, and returns the sequencer to idle.
// The receiver cannot stall: every strobe beat must be taken as it comes.
module poly_voice_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [15:0] i_voice_mask,
    input  logic [4:0]  i_poly_limit,
    input  logic [1:0]  i_steal_mode,
    input  logic [3:0]  i_target_slot,
    output logic        o_strobe,
    output logic [3:0]  o_slot,
    output logic        o_valid_res,
    output logic        o_gated,
    output logic [3:0]  o_slot_channel,
    output logic [6:0]  o_slot_note,
    output logic [6:0]  o_slot_velocity
);
    import pva_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pva_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_note          (i_note),
        .i_velocity      (i_velocity),
        .i_voice_mask    (i_voice_mask),
        .i_poly_limit    (i_poly_limit),
        .i_steal_mode    (i_steal_mode),
        .i_target_slot   (i_target_slot),
        .o_strobe        (o_strobe),
        .o_slot          (o_slot),
        .o_valid_res     (o_valid_res),
        .o_gated         (o_gated),
        .o_slot_channel  (o_slot_channel),
        .o_slot_note     (o_slot_note),
        .o_slot_velocity (o_slot_velocity)
    );

endmodule

### sim/tb_poly_voice_allocator_unit.sv
// Self-checking testbench for poly_voice_allocator_unit: directed and random commands.
module tb_poly_voice_allocator_unit;
    import pva_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int N_RANDOM    = 1225;
    localparam int N_TAIL      = 150;

    typedef struct packed {
        t_op        op;
        logic [3:0] channel;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [15:0] mask;
        logic [4:0] limit;
        t_steal     mode;
        logic [3:0] target;
    } t_voice_cmd;

    typedef struct packed {
        logic [3:0] slot;
        logic       hit;
        logic       gated;
        logic [3:0] channel;
        logic [6:0] pitch;
        logic [6:0] velocity;
    } t_voice_res;

    // voice table predictor plus queue of expected result beats
    class voice_scoreboard;
        bit          slot_gated[VOICES];
        bit [3:0]    slot_chan[VOICES];
        bit [6:0]    slot_pitch[VOICES];
        bit [6:0]    slot_vel[VOICES];
        bit [31:0]   slot_age[VOICES];
        bit [31:0]   serial;
        t_voice_res  pending[$];
        int unsigned errors, n_alloc, n_retrig, n_steal, n_refused;
        int unsigned n_found, n_release, n_read;

        function new();
            for (int i = 0; i < VOICES; i++) begin
                slot_gated[i] = 0;
                slot_chan[i]  = '0;
                slot_pitch[i] = '0;
                slot_vel[i]   = '0;
                slot_age[i]   = '0;
            end
            serial = '0;
        endfunction

        function int find_gated(logic [3:0] ch, logic [6:0] nt);
            for (int i = 0; i < VOICES; i++)
                if (slot_gated[i] && slot_chan[i] == ch && slot_pitch[i] == nt)
                    return i;
            return -1;
        endfunction

        // ties keep the lowest index
        function int pick_victim(bit [VOICES-1:0] cand, t_steal mode);
            int pick;
            pick = -1;
            if (mode == STEAL_NONE)
                return -1;
            for (int i = 0; i < VOICES; i++) begin
                if (!cand[i] || !slot_gated[i])
                    continue;
                if (pick < 0)
                    pick = i;
                else if (mode == STEAL_OLD && slot_age[i] < slot_age[pick])
                    pick = i;
                else if (mode == STEAL_LOW && slot_pitch[i] < slot_pitch[pick])
                    pick = i;
                else if (mode == STEAL_HIGH && slot_pitch[i] > slot_pitch[pick])
                    pick = i;
            end
            return pick;
        endfunction

        function int allocate(t_voice_cmd c);
            int s;
            int held;
            int lim;
            bit [VOICES-1:0] own;
            bit [VOICES-1:0] eligible;
            s = find_gated(c.channel, c.pitch);
            if (s >= 0) begin
                slot_vel[s] = c.velocity;
                serial++;
                slot_age[s] = serial;
                n_retrig++;
                return s;
            end
            eligible = c.mask[VOICES-1:0];
            if (eligible == '0)
                return -1;
            lim  = (c.limit == 0) ? 1 : int'(c.limit);
            held = 0;
            own  = '0;
            for (int i = 0; i < VOICES; i++)
                if (slot_gated[i] && slot_chan[i] == c.channel) begin
                    held++;
                    own[i] = 1'b1;
                end
            if (held >= lim)
                s = pick_victim(own, c.mode);
            else begin
                for (int i = 0; i < VOICES; i++)
                    if (s < 0 && eligible[i] && !slot_gated[i])
                        s = i;
                if (s < 0)
                    s = pick_victim(eligible, c.mode);
            end
            if (s < 0)
                return -1;
            if (slot_gated[s])
                n_steal++;
            slot_chan[s]  = c.channel;
            slot_pitch[s] = c.pitch;
            slot_vel[s]   = c.velocity;
            serial++;
            slot_age[s]   = serial;
            slot_gated[s] = 1;
            return s;
        endfunction

        function void note_command(t_voice_cmd c);
            t_voice_res r;
            int s;
            r = '0;
            case (c.op)
                OP_ALLOC, OP_FIND: begin
                    if (c.op == OP_ALLOC) begin
                        n_alloc++;
                        s = allocate(c);
                        if (s < 0)
                            n_refused++;
                    end else begin
                        s = find_gated(c.channel, c.pitch);
                        if (s >= 0)
                            n_found++;
                    end
                    if (s >= 0) begin
                        r.slot = s[3:0];
                        r.hit  = 1'b1;
                    end
                end
                default: begin
                    r.slot = c.target;
                    if (c.op == OP_RELEASE)
                        n_release++;
                    else
                        n_read++;
                    if (c.target < VOICES) begin
                        r.hit = 1'b1;
                        if (c.op == OP_RELEASE) begin
                            // velocity survives a release
                            slot_gated[c.target] = 0;
                            slot_chan[c.target]  = '0;
                            slot_pitch[c.target] = '0;
                        end else begin
                            r.gated    = slot_gated[c.target];
                            r.channel  = slot_chan[c.target];
                            r.pitch    = slot_pitch[c.target];
                            r.velocity = slot_vel[c.target];
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(t_voice_res got);
            t_voice_res want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: slot=%0d hit=%0b", got.slot, got.hit);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp slot=%0d hit=%0b gated=%0b ch=%0d note=%0d vel=%0d",
                             want.slot, want.hit, want.gated, want.channel, want.pitch,
                             want.velocity);
                    $display("          got slot=%0d hit=%0b gated=%0b ch=%0d note=%0d vel=%0d",
                             got.slot, got.hit, got.gated, got.channel, got.pitch,
                             got.velocity);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [3:0]  i_channel = '0;
    logic [6:0]  i_note = '0;
    logic [6:0]  i_velocity = '0;
    logic [15:0] i_voice_mask = '0;
    logic [4:0]  i_poly_limit = '0;
    logic [1:0]  i_steal_mode = '0;
    logic [3:0]  i_target_slot = '0;
    logic        o_strobe;
    logic [3:0]  o_slot;
    logic        o_valid_res;
    logic        o_gated;
    logic [3:0]  o_slot_channel;
    logic [6:0]  o_slot_note;
    logic [6:0]  o_slot_velocity;

    voice_scoreboard sb = new();
    int unsigned     quiet_cycles = 0;

    poly_voice_allocator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_note          (i_note),
        .i_velocity      (i_velocity),
        .i_voice_mask    (i_voice_mask),
        .i_poly_limit    (i_poly_limit),
        .i_steal_mode    (i_steal_mode),
        .i_target_slot   (i_target_slot),
        .o_strobe        (o_strobe),
        .o_slot          (o_slot),
        .o_valid_res     (o_valid_res),
        .o_gated         (o_gated),
        .o_slot_channel  (o_slot_channel),
        .o_slot_note     (o_slot_note),
        .o_slot_velocity (o_slot_velocity)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result beats cannot be held off; take each one as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result({o_slot, o_valid_res, o_gated, o_slot_channel,
                             o_slot_note, o_slot_velocity});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic t_voice_cmd make_cmd(t_op op, int ch, int nt, int vel, int mask,
                                            int lim, t_steal mode, int tgt);
        t_voice_cmd c;
        c.op       = op;
        c.channel  = 4'(ch);
        c.pitch    = 7'(nt);
        c.velocity = 7'(vel);
        c.mask     = 16'(mask);
        c.limit    = 5'(lim);
        c.mode     = mode;
        c.target   = 4'(tgt);
        return c;
    endfunction

    // small channel and note pools so retriggers, finds and steals happen often
    function automatic t_voice_cmd random_cmd();
        t_voice_cmd c;
        int         roll;
        c.channel  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        c.pitch    = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(0, 9));
        c.velocity = 7'($urandom);
        case ($urandom_range(0, 9))
            5, 6:    c.mask = 16'($urandom);
            7:       c.mask = 16'(1) << $urandom_range(0, 15);
            8:       c.mask = '0;
            9:       c.mask = 16'($urandom_range(0, 255)) & 16'h00F0 | 16'($urandom) & 16'hFF00;
            default: c.mask = 16'hFFFF;
        endcase
        c.limit  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 16))
                                               : 5'($urandom_range(0, 4));
        c.mode   = t_steal'($urandom_range(0, 3));
        c.target = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, VOICES - 1));
        roll = $urandom_range(0, 99);
        if (roll < 45)
            c.op = OP_ALLOC;
        else if (roll < 65)
            c.op = OP_FIND;
        else if (roll < 85)
            c.op = OP_RELEASE;
        else
            c.op = OP_READ;
        return c;
    endfunction

    // start stays high from one beat to the next unless a gap follows
    task automatic issue(input t_voice_cmd c);
        start         <= 1'b1;
        i_op          <= c.op;
        i_channel     <= c.channel;
        i_note        <= c.pitch;
        i_velocity    <= c.velocity;
        i_voice_mask  <= c.mask;
        i_poly_limit  <= c.limit;
        i_steal_mode  <= c.mode;
        i_target_slot <= c.target;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(c);
    endtask

    // fields carry junk while start is low
    task automatic sender_gap(input int n);
        start         <= 1'b0;
        i_op          <= 2'($urandom);
        i_channel     <= 4'($urandom);
        i_note        <= 7'($urandom);
        i_velocity    <= 7'($urandom);
        i_voice_mask  <= 16'($urandom);
        i_poly_limit  <= 5'($urandom);
        i_steal_mode  <= 2'($urandom);
        i_target_slot <= 4'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        bit gaps_on;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset contents, out-of-range slot, empty mask, retrigger, limit steal
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, STEAL_NONE, 15));
        issue(make_cmd(OP_RELEASE, 0, 0, 0, 0, 0, STEAL_NONE, 15));
        issue(make_cmd(OP_FIND, 0, 0, 0, 0, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_ALLOC, 0, 0, 0, 0, 0, STEAL_OLD, 0));
        issue(make_cmd(OP_ALLOC, 0, 0, 0, 16'hFFFF << VOICES, 16, STEAL_OLD, 0));
        issue(make_cmd(OP_ALLOC, 0, 0, 127, 16'hFFFF, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_ALLOC, 0, 0, 5, 16'hFFFF, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_ALLOC, 0, 127, 9, 16'hFFFF, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_ALLOC, 0, 127, 9, 16'hFFFF, 0, STEAL_OLD, 0));
        issue(make_cmd(OP_FIND, 0, 127, 0, 0, 0, STEAL_NONE, 0));
        for (int i = 1; i < VOICES; i++)
            issue(make_cmd(OP_ALLOC, 15, 10 + 13 * i, 127, 16'hFFFF, 16, STEAL_NONE, 0));
        // table full: refuse, then steal lowest, highest, oldest within the mask
        issue(make_cmd(OP_ALLOC, 3, 64, 1, 16'hFFFF, 16, STEAL_NONE, 0));
        issue(make_cmd(OP_ALLOC, 3, 64, 2, 16'hFFFF, 16, STEAL_LOW, 0));
        issue(make_cmd(OP_ALLOC, 3, 65, 3, 16'hFFFF, 16, STEAL_HIGH, 0));
        issue(make_cmd(OP_ALLOC, 3, 66, 4, 16'hFFFF, 16, STEAL_OLD, 0));
        issue(make_cmd(OP_RELEASE, 0, 0, 0, 0, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_RELEASE, 0, 0, 0, 0, 0, STEAL_NONE, 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, STEAL_NONE, VOICES - 1));

        gaps_on = 1'b1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 60 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            issue(random_cmd());
            if (n < N_RANDOM - N_TAIL && gaps_on && $urandom_range(0, 2) == 0)
                sender_gap($urandom_range(1, 9));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (2 * (VOICES + 3)) @(posedge i_clk);

        $display("Ran %0d allocs (%0d retriggers, %0d steals, %0d refused), %0d finds hit,",
                 sb.n_alloc, sb.n_retrig, sb.n_steal, sb.n_refused, sb.n_found);
        $display("%0d releases and %0d reads; %0d mismatches",
                 sb.n_release, sb.n_read, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
